// File: src/union_find_set_engine_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the union-find set engine checker
// Clock clk and active-low reset rst_n are taken from the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_SET_ENGINE_TOP_ASSERT_SVH
`define UNION_FIND_SET_ENGINE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define UFSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define UFSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ufse_pkg.sv
// ---------------------------------------------------------------------------
// ufse_pkg
// Shared constants of the union-find set engine: stream widths and opcodes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufse_pkg;

    localparam int ELEM_W     = 10;  // element index field width
    localparam int SIZE_OUT_W = 11;  // set size field width
    localparam int IN_DATA_W  = 24;  // first_element, second_element, padding
    localparam int IN_USER_W  = 1;   // operation
    localparam int OUT_DATA_W = 24;  // root, set_size, merged, padding
    localparam int RED_STEP_W = 4;   // counts ELEM_W reduction steps

    localparam int OUT_SIZE_LSB   = ELEM_W;
    localparam int OUT_MERGED_BIT = ELEM_W + SIZE_OUT_W;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

endpackage

// File: src/union_find_set_engine_top.sv
// ---------------------------------------------------------------------------
// union_find_set_engine_top
// Disjoint-set engine, union by size with full path compression. The forest
// lives in one simple dual-port link memory (flag, parent or size per entry).
// ---------------------------------------------------------------------------
// channel  | ports              | payload (low bit up)
// ---------+--------------------+---------------------------------------------
// request  | s_axis_t*          | tuser: operation; tdata: first_element,
//          |                    |   second_element
// result   | m_axis_t*          | tdata: root, set_size, merged
//
// After reset a clearing pass writes every entry as a singleton root while
// s_axis_tready is low. Find: a root walk, compression of the walked path
// and output, one memory read per cycle; union: a walk and compression for
// each operand, then merge, link and output (merge goes straight to output
// when both roots match). With ELEMENT_COUNT below 1024 an index reduction
// runs first. One request is in flight at a time; the result register lets
// the next request enter while a result still waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_set_engine_top #(
    parameter int ELEMENT_COUNT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] first_element, [19:10] second_element, [23:20] zero
    input  logic [ufse_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic [ufse_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] root, [20:10] set_size, [21] merged, [23:22] zero
    output logic [ufse_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W = $clog2(ELEMENT_COUNT);
    localparam int VAL_W = $clog2(ELEMENT_COUNT + 1);
    localparam int ENT_W = VAL_W + 1;
    localparam int EW    = ufse_pkg::ELEM_W;
    localparam int SW    = ufse_pkg::SIZE_OUT_W;
    localparam int RW    = ufse_pkg::RED_STEP_W;

    localparam bit            NEED_RED = (ELEMENT_COUNT < (2 ** EW));
    localparam logic [RW-1:0] RED_LAST = RW'(EW - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_START,
        ST_WALK,
        ST_COMP,
        ST_MERGE,
        ST_LINK,
        ST_FINISH
    } state_t;

    // entry: [VAL_W] root flag, [VAL_W-1:0] parent (non-root) or set size (root)
    logic [ENT_W-1:0] link_mem [ELEMENT_COUNT];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    state_t           state_reg,      state_next;
    logic [IDX_W-1:0] clr_cnt_reg,    clr_cnt_next;
    logic             op_reg,         op_next;
    logic [EW-1:0]    a_val_reg,      a_val_next;
    logic [EW-1:0]    b_val_reg,      b_val_next;
    logic [RW-1:0]    red_step_reg,   red_step_next;
    logic             pass_b_reg,     pass_b_next;
    logic [IDX_W-1:0] cur_reg,        cur_next;
    logic [IDX_W-1:0] root_a_reg,     root_a_next;
    logic [IDX_W-1:0] root_b_reg,     root_b_next;
    logic [VAL_W-1:0] size_a_reg,     size_a_next;
    logic [VAL_W-1:0] size_b_reg,     size_b_next;
    logic             merged_reg,     merged_next;
    logic             out_valid_reg,  out_valid_next;
    logic [EW-1:0]    out_root_reg,   out_root_next;
    logic [SW-1:0]    out_size_reg,   out_size_next;
    logic             out_merged_reg, out_merged_next;

    logic             rd_is_root;
    logic [IDX_W-1:0] rd_link;
    logic [IDX_W-1:0] start_elem;
    logic [IDX_W-1:0] cur_root;
    logic [31:0]      red_thr;
    logic             pass_done;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    assign rd_is_root = rd_data_reg[VAL_W];
    assign rd_link    = IDX_W'(rd_data_reg[VAL_W-1:0]);
    assign start_elem = pass_b_reg ? IDX_W'(b_val_reg) : IDX_W'(a_val_reg);
    assign cur_root   = pass_b_reg ? root_b_reg : root_a_reg;
    assign red_thr    = 32'(ELEMENT_COUNT) << red_step_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (ufse_pkg::OUT_DATA_W - EW - SW - 1)'(0), out_merged_reg, out_size_reg, out_root_reg
    };

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        a_val_next      = a_val_reg;
        b_val_next      = b_val_reg;
        red_step_next   = red_step_reg;
        pass_b_next     = pass_b_reg;
        cur_next        = cur_reg;
        root_a_next     = root_a_reg;
        root_b_next     = root_b_reg;
        size_a_next     = size_a_reg;
        size_b_next     = size_b_reg;
        merged_next     = merged_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_root_next   = out_root_reg;
        out_size_next   = out_size_reg;
        out_merged_next = out_merged_reg;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;
        pass_done       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = {1'b1, VAL_W'(1)};
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next       = s_axis_tuser[0];
                    a_val_next    = s_axis_tdata[EW-1:0];
                    b_val_next    = s_axis_tdata[2*EW-1:EW];
                    red_step_next = RED_LAST;
                    pass_b_next   = 1'b0;
                    merged_next   = 1'b0;
                    state_next    = NEED_RED ? ST_REDUCE : ST_START;
                end
            end

            // restoring reduction modulo ELEMENT_COUNT, one shifted compare per cycle
            ST_REDUCE:
            begin
                if (32'(a_val_reg) >= red_thr)
                begin
                    a_val_next = a_val_reg - EW'(red_thr);
                end
                if (32'(b_val_reg) >= red_thr)
                begin
                    b_val_next = b_val_reg - EW'(red_thr);
                end
                if (red_step_reg == '0)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    red_step_next = red_step_reg - 1'b1;
                end
            end

            ST_START:
            begin
                rd_addr    = start_elem;
                cur_next   = start_elem;
                state_next = ST_WALK;
            end

            // rd_data_reg holds entry cur_reg
            ST_WALK:
            begin
                if (rd_is_root)
                begin
                    if (pass_b_reg)
                    begin
                        root_b_next = cur_reg;
                        size_b_next = rd_data_reg[VAL_W-1:0];
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        size_a_next = rd_data_reg[VAL_W-1:0];
                    end
                    if (cur_reg == start_elem)
                    begin
                        pass_done = 1'b1;
                    end
                    else
                    begin
                        rd_addr    = start_elem;
                        cur_next   = start_elem;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    rd_addr  = rd_link;
                    cur_next = rd_link;
                end
            end

            // repoint cur_reg at the root while the next path node is read
            ST_COMP:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {1'b0, VAL_W'(cur_root)};
                if (rd_link == cur_root)
                begin
                    pass_done = 1'b1;
                end
                else
                begin
                    rd_addr  = rd_link;
                    cur_next = rd_link;
                end
            end

            ST_MERGE:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // tie keeps the first root on top
                    if (size_a_reg < size_b_reg)
                    begin
                        root_a_next = root_b_reg;
                        root_b_next = root_a_reg;
                        wr_addr     = root_b_reg;
                    end
                    else
                    begin
                        wr_addr = root_a_reg;
                    end
                    size_a_next = VAL_W'(size_a_reg + size_b_reg);
                    wr_en       = 1'b1;
                    wr_data     = {1'b1, VAL_W'(size_a_reg + size_b_reg)};
                    merged_next = 1'b1;
                    state_next  = ST_LINK;
                end
            end

            ST_LINK:
            begin
                wr_en      = 1'b1;
                wr_addr    = root_b_reg;
                wr_data    = {1'b0, VAL_W'(root_a_reg)};
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = EW'(root_a_reg);
                    out_size_next   = SW'(size_a_reg);
                    out_merged_next = merged_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one root walk and its compression finished
        if (pass_done)
        begin
            if (op_reg == ufse_pkg::OP_UNION)
            begin
                if (pass_b_reg)
                begin
                    state_next = ST_MERGE;
                end
                else
                begin
                    pass_b_next = 1'b1;
                    state_next  = ST_START;
                end
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            op_reg         <= ufse_pkg::OP_FIND;
            a_val_reg      <= '0;
            b_val_reg      <= '0;
            red_step_reg   <= '0;
            pass_b_reg     <= 1'b0;
            cur_reg        <= '0;
            root_a_reg     <= '0;
            root_b_reg     <= '0;
            size_a_reg     <= '0;
            size_b_reg     <= '0;
            merged_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_root_reg   <= '0;
            out_size_reg   <= '0;
            out_merged_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            op_reg         <= op_next;
            a_val_reg      <= a_val_next;
            b_val_reg      <= b_val_next;
            red_step_reg   <= red_step_next;
            pass_b_reg     <= pass_b_next;
            cur_reg        <= cur_next;
            root_a_reg     <= root_a_next;
            root_b_reg     <= root_b_next;
            size_a_reg     <= size_a_next;
            size_b_reg     <= size_b_next;
            merged_reg     <= merged_next;
            out_valid_reg  <= out_valid_next;
            out_root_reg   <= out_root_next;
            out_size_reg   <= out_size_next;
            out_merged_reg <= out_merged_next;
        end
    end

endmodule

// File: src/ufse_checker.sv
// ---------------------------------------------------------------------------
// ufse_checker
// Port-level checks on the union-find set engine, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "union_find_set_engine_top_assert.svh"

module ufse_checker #(
    parameter int ELEMENT_COUNT = 1024
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ufse_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ufse_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ufse_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                               req_acc;
    logic [ufse_pkg::ELEM_W-1:0]        out_root;
    logic [ufse_pkg::SIZE_OUT_W-1:0]    out_size;
    logic                               out_merged;

    assign req_acc    = s_axis_tvalid && s_axis_tready;
    assign out_root   = m_axis_tdata[ufse_pkg::ELEM_W-1:0];
    assign out_size   = m_axis_tdata[ufse_pkg::OUT_MERGED_BIT-1:ufse_pkg::OUT_SIZE_LSB];
    assign out_merged = m_axis_tdata[ufse_pkg::OUT_MERGED_BIT];

    `UFSE_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `UFSE_ASSERT_NEXT(a_one_in_flight, req_acc, !s_axis_tready,
        "request accepted while another was in work")

    `UFSE_ASSERT_SAME(a_merge_size, m_axis_tvalid && out_merged,
        (ELEMENT_COUNT >= 2048) || (out_size >= 11'd2), "merged set smaller than two")

    `UFSE_ASSERT_SAME(a_root_range, m_axis_tvalid,
        (ELEMENT_COUNT >= 1024) || (32'(out_root) < ELEMENT_COUNT), "root out of range")

endmodule

bind union_find_set_engine_top ufse_checker #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
) u_ufse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - union-find set engine
// Streams find and union requests into the engine and keeps its own forest
// (union by size, full path compression) to predict root, set size and merge
// flag of every result. Sender bursts and receiver stalls are randomized.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [ufse_pkg::ELEM_W-1:0]     root;
    logic [ufse_pkg::SIZE_OUT_W-1:0] set_size;
    logic                            merged;
} root_report_t;

class set_forest_scoreboard;
    localparam int NODES = 1 << ufse_pkg::ELEM_W;

    bit           is_root   [NODES];
    int unsigned  up_link   [NODES];
    int unsigned  set_count [NODES];
    root_report_t awaited_roots[$];
    int           mismatches;

    function new();
        for (int i = 0; i < NODES; i++)
        begin
            is_root[i]   = 1'b1;
            up_link[i]   = i;
            set_count[i] = 1;
        end
        mismatches = 0;
    endfunction

    // walk to the root, then repoint the walked path straight at it
    function int unsigned find_root_compress(int unsigned node);
        int unsigned r;
        int unsigned nxt;
        int unsigned steps;
        r     = node;
        steps = 0;
        while (!is_root[r] && steps < NODES)
        begin
            r = up_link[r] % NODES;
            steps++;
        end
        steps = 0;
        while (node != r && !is_root[node] && steps < NODES)
        begin
            nxt           = up_link[node] % NODES;
            up_link[node] = r;
            node          = nxt;
            steps++;
        end
        return r;
    endfunction

    function void note_request(logic op, logic [ufse_pkg::ELEM_W-1:0] first_elem,
                               logic [ufse_pkg::ELEM_W-1:0] second_elem);
        int unsigned  ra;
        int unsigned  rb;
        int unsigned  tmp;
        root_report_t rep;
        rep.merged = 1'b0;
        ra = find_root_compress(first_elem % NODES);
        if (op == ufse_pkg::OP_UNION)
        begin
            rb = find_root_compress(second_elem % NODES);
            if (ra != rb)
            begin
                // smaller set hangs under the larger; tie keeps the first root
                if (set_count[ra] < set_count[rb])
                begin
                    tmp = ra;
                    ra  = rb;
                    rb  = tmp;
                end
                set_count[ra] += set_count[rb];
                is_root[rb]    = 1'b0;
                up_link[rb]    = ra;
                set_count[rb]  = 0;
                rep.merged     = 1'b1;
            end
        end
        rep.root     = ra[ufse_pkg::ELEM_W-1:0];
        rep.set_size = set_count[ra][ufse_pkg::SIZE_OUT_W-1:0];
        awaited_roots.push_back(rep);
    endfunction

    function int outstanding();
        return awaited_roots.size();
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [ufse_pkg::OUT_DATA_W-1:0] word);
        root_report_t want;
        logic [ufse_pkg::SIZE_OUT_W-1:0] got_size;
        if (awaited_roots.size() == 0)
        begin
            report_mismatch($sformatf("result 0x%06h with no request waiting", word));
            return;
        end
        want     = awaited_roots.pop_front();
        got_size = word[ufse_pkg::OUT_SIZE_LSB +: ufse_pkg::SIZE_OUT_W];
        if (word[ufse_pkg::ELEM_W-1:0] !== want.root)
            report_mismatch($sformatf("root got %0d, expected %0d",
                                      word[ufse_pkg::ELEM_W-1:0], want.root));
        if (got_size !== want.set_size)
            report_mismatch($sformatf("set_size got %0d, expected %0d",
                                      got_size, want.set_size));
        if (word[ufse_pkg::OUT_MERGED_BIT] !== want.merged)
            report_mismatch($sformatf("merged got %0b, expected %0b",
                                      word[ufse_pkg::OUT_MERGED_BIT], want.merged));
        if (word[ufse_pkg::OUT_DATA_W-1:ufse_pkg::OUT_MERGED_BIT+1] !== '0)
            report_mismatch($sformatf("padding bits not zero in 0x%06h", word));
    endtask
endclass

module tb;
    localparam int ELEM_W     = ufse_pkg::ELEM_W;
    localparam int IN_DATA_W  = ufse_pkg::IN_DATA_W;
    localparam int IN_USER_W  = ufse_pkg::IN_USER_W;
    localparam int OUT_DATA_W = ufse_pkg::OUT_DATA_W;
    localparam int NODES      = 1 << ELEM_W;
    localparam int IDLE_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    set_forest_scoreboard board = new();

    int burst_left = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;
    int idle_cycles = 0;

    union_find_set_engine_top #(
        .ELEMENT_COUNT(NODES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // bursts of back-to-back requests separated by random gaps
    task automatic send_request(input logic op, input logic [ELEM_W-1:0] first_elem,
                                input logic [ELEM_W-1:0] second_elem);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W-2*ELEM_W){1'b0}}, second_elem, first_elem};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(op, first_elem, second_elem);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // receiver: phases of always ready, random ready and mostly stalled
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if (rx_phase_left == 0)
        begin
            rx_mode       <= $urandom_range(0, 2);
            rx_phase_left <= $urandom_range(8, 64);
        end
        else
            rx_phase_left <= rx_phase_left - 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] window_base;
        logic              op;
        int                window_span;
        int                window_left;
        int                j;

        window_base = '0;
        window_span = 1;
        window_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, tie, same set, same element, compression
        send_request(ufse_pkg::OP_FIND,  10'd0,    10'd1023);
        send_request(ufse_pkg::OP_FIND,  10'd1023, 10'd0);
        send_request(ufse_pkg::OP_UNION, 10'd0,    10'd1);
        send_request(ufse_pkg::OP_UNION, 10'd1,    10'd0);
        send_request(ufse_pkg::OP_UNION, 10'd2,    10'd2);
        send_request(ufse_pkg::OP_UNION, 10'd3,    10'd0);
        send_request(ufse_pkg::OP_UNION, 10'd1023, 10'd1022);
        send_request(ufse_pkg::OP_UNION, 10'd1022, 10'd0);
        send_request(ufse_pkg::OP_FIND,  10'd1022, 10'd1023);
        send_request(ufse_pkg::OP_FIND,  10'd1023, 10'd1023);
        send_request(ufse_pkg::OP_UNION, 10'd512,  10'd513);
        send_request(ufse_pkg::OP_UNION, 10'd514,  10'd515);
        send_request(ufse_pkg::OP_UNION, 10'd515,  10'd513);
        send_request(ufse_pkg::OP_UNION, 10'd516,  10'd512);
        send_request(ufse_pkg::OP_FIND,  10'd516,  10'd682);
        send_request(ufse_pkg::OP_UNION, 10'd341,  10'd682);
        send_request(ufse_pkg::OP_UNION, 10'd682,  10'd514);
        drain_results();

        // random: half the operands from a sliding window to build deep trees
        for (int i = 0; i < 800; i++)
        begin
            if (window_left == 0)
            begin
                window_base = ELEM_W'($urandom);
                window_span = $urandom_range(8, 64);
                window_left = $urandom_range(20, 80);
            end
            window_left--;
            a  = $urandom_range(0, 1)
                 ? ELEM_W'(window_base + $urandom_range(0, window_span - 1))
                 : ELEM_W'($urandom);
            b  = $urandom_range(0, 1)
                 ? ELEM_W'(window_base + $urandom_range(0, window_span - 1))
                 : ELEM_W'($urandom);
            op = ($urandom_range(0, 9) < 6) ? ufse_pkg::OP_UNION : ufse_pkg::OP_FIND;
            send_request(op, a, b);
            if (i == 400)
                drain_results();
        end

        // join every element into one set, reaching the full set size
        for (int i = 1; i < NODES; i++)
        begin
            j = $urandom_range(0, i - 1);
            if ($urandom_range(0, 1))
                send_request(ufse_pkg::OP_UNION, i[ELEM_W-1:0], j[ELEM_W-1:0]);
            else
                send_request(ufse_pkg::OP_UNION, j[ELEM_W-1:0], i[ELEM_W-1:0]);
            if ($urandom_range(0, 7) == 0)
                send_request(ufse_pkg::OP_FIND, ELEM_W'($urandom), ELEM_W'($urandom));
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
